>>> rtl/lsmc_pkg.sv
// Shared constants, types and the neighbourhood table of the mean curvature block.
package lsmc_pkg;

	localparam int MAX_PLANES_DEF = 256;
	localparam int MAX_ROWS_DEF   = 64;
	localparam int MAX_COLS_DEF   = 64;

	// pending voxel words between front and back
	localparam int QUEUE_DEPTH = 4;

	localparam int PHI_W      = 24;
	localparam int CURV_W     = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int EPS_W      = 16;
	localparam int EXT_X_W    = 9;
	localparam int EXT_YZ_W   = 7;

	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 3'd3;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_DRAIN  = 1'b1;

	// 19-point neighbourhood: plane, row and column offsets of each tap
	localparam int NB_COUNT = 19;
	localparam logic [4:0] NB_U0  = 5'd0;
	localparam logic [4:0] NB_U1  = 5'd1;
	localparam logic [4:0] NB_U1M = 5'd2;
	localparam logic [4:0] NB_U1P = 5'd3;
	localparam logic [4:0] NB_U2  = 5'd4;
	localparam logic [4:0] NB_U3  = 5'd5;
	localparam logic [4:0] NB_U3M = 5'd6;
	localparam logic [4:0] NB_U3P = 5'd7;
	localparam logic [4:0] NB_U4  = 5'd8;
	localparam logic [4:0] NB_U4M = 5'd9;
	localparam logic [4:0] NB_U4P = 5'd10;
	localparam logic [4:0] NB_U5  = 5'd11;
	localparam logic [4:0] NB_U5M = 5'd12;
	localparam logic [4:0] NB_U5P = 5'd13;
	localparam logic [4:0] NB_U6  = 5'd14;
	localparam logic [4:0] NB_U7  = 5'd15;
	localparam logic [4:0] NB_U7M = 5'd16;
	localparam logic [4:0] NB_U7P = 5'd17;
	localparam logic [4:0] NB_U8  = 5'd18;

	typedef enum logic [1:0] {
		OFF_MINUS,
		OFF_ZERO,
		OFF_PLUS
	} off_t;

	typedef struct packed {
		off_t di;
		off_t dj;
		off_t dk;
	} nb_off_t;

	function automatic nb_off_t nb_offset(input logic [4:0] idx);
		nb_off_t o;
		case (idx)
			NB_U0:   o = '{OFF_MINUS, OFF_MINUS, OFF_ZERO};
			NB_U1:   o = '{OFF_MINUS, OFF_ZERO,  OFF_ZERO};
			NB_U1M:  o = '{OFF_MINUS, OFF_ZERO,  OFF_MINUS};
			NB_U1P:  o = '{OFF_MINUS, OFF_ZERO,  OFF_PLUS};
			NB_U2:   o = '{OFF_MINUS, OFF_PLUS,  OFF_ZERO};
			NB_U3:   o = '{OFF_ZERO,  OFF_MINUS, OFF_ZERO};
			NB_U3M:  o = '{OFF_ZERO,  OFF_MINUS, OFF_MINUS};
			NB_U3P:  o = '{OFF_ZERO,  OFF_MINUS, OFF_PLUS};
			NB_U4:   o = '{OFF_ZERO,  OFF_ZERO,  OFF_ZERO};
			NB_U4M:  o = '{OFF_ZERO,  OFF_ZERO,  OFF_MINUS};
			NB_U4P:  o = '{OFF_ZERO,  OFF_ZERO,  OFF_PLUS};
			NB_U5:   o = '{OFF_ZERO,  OFF_PLUS,  OFF_ZERO};
			NB_U5M:  o = '{OFF_ZERO,  OFF_PLUS,  OFF_MINUS};
			NB_U5P:  o = '{OFF_ZERO,  OFF_PLUS,  OFF_PLUS};
			NB_U6:   o = '{OFF_PLUS,  OFF_MINUS, OFF_ZERO};
			NB_U7:   o = '{OFF_PLUS,  OFF_ZERO,  OFF_ZERO};
			NB_U7M:  o = '{OFF_PLUS,  OFF_ZERO,  OFF_MINUS};
			NB_U7P:  o = '{OFF_PLUS,  OFF_ZERO,  OFF_PLUS};
			NB_U8:   o = '{OFF_PLUS,  OFF_PLUS,  OFF_ZERO};
			default: o = '{OFF_ZERO,  OFF_ZERO,  OFF_ZERO};
		endcase
		return o;
	endfunction

endpackage

>>> rtl/lsmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsmc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/lsmc_fifo.sv
// Short register queue carrying voxel words from the front to the back.
module lsmc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

>>> rtl/lsmc_front.sv
// Front end: configuration, sample store writes and classification of voxels to answer.
module lsmc_front import lsmc_pkg::*; #(
	parameter int MAX_PLANES = MAX_PLANES_DEF,
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF,
	localparam int XW  = $clog2(MAX_PLANES + 1),
	localparam int YW  = $clog2(MAX_ROWS + 1),
	localparam int ZW  = $clog2(MAX_COLS + 1),
	localparam int PLW = $clog2(MAX_ROWS * MAX_COLS + 1),
	localparam int AW  = $clog2(2 * MAX_ROWS * MAX_COLS + 2 * MAX_COLS + QUEUE_DEPTH + 3),
	localparam int EW  = XW + YW + ZW + AW + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic signed [PHI_W-1:0] phi_value,
	output logic                  mem_we,
	output logic [AW-1:0]         mem_waddr,
	output logic [PHI_W-1:0]      mem_wdata,
	output logic                  q_push,
	output logic [EW-1:0]         q_data,
	input  logic                  q_full,
	output logic [XW-1:0]         ext_x,
	output logic [YW-1:0]         ext_y,
	output logic [ZW-1:0]         ext_z,
	output logic [PLW-1:0]        plane_size,
	output logic [EPS_W-1:0]      eps
);

	localparam int TW = $clog2(MAX_PLANES * MAX_ROWS * MAX_COLS + 1);

	logic [EXT_X_W-1:0]  ext_x_q;
	logic [EXT_YZ_W-1:0] ext_y_q, ext_z_q;
	logic [EPS_W-1:0]    eps_q;
	logic [1:0]          settle_q;

	logic [XW-1:0]  xc_c, xc_q;
	logic [YW-1:0]  yc_c, yc_q;
	logic [ZW-1:0]  zc_c, zc_q;
	logic [YW+ZW-1:0] pyz;
	logic [PLW-1:0] p_q;
	logic [PLW:0]   pz_q;
	logic [XW+PLW-1:0] txp;
	logic [TW-1:0]  total_q;

	logic [TW-1:0] wp_q, ep_q;
	logic [XW-1:0] ei_q;
	logic [YW-1:0] ej_q;
	logic [ZW-1:0] ek_q;

	// ring addresses run on across regions so a new region never overwrites
	// the window of voxels the back is still answering
	logic [AW-1:0]    wa_q, ra_q;
	logic [TW:0]      ahead;
	logic             cfg_hit, accept, store, emit, last_c;

	// clamp the extents to 1..max
	always_comb begin
		if (ext_x_q == '0) xc_c = XW'(1);
		else if (int'(ext_x_q) > MAX_PLANES) xc_c = XW'(MAX_PLANES);
		else xc_c = XW'(ext_x_q);
		if (ext_y_q == '0) yc_c = YW'(1);
		else if (int'(ext_y_q) > MAX_ROWS) yc_c = YW'(MAX_ROWS);
		else yc_c = YW'(ext_y_q);
		if (ext_z_q == '0) zc_c = ZW'(1);
		else if (int'(ext_z_q) > MAX_COLS) zc_c = ZW'(MAX_COLS);
		else zc_c = ZW'(ext_z_q);
	end

	assign pyz = yc_c * zc_c;
	assign txp = xc_q * p_q;

	// derived sizes: extents and plane size registered first, then total_q and pz_q
	always_ff @(posedge clk) begin
		xc_q    <= xc_c;
		yc_q    <= yc_c;
		zc_q    <= zc_c;
		p_q     <= PLW'(pyz);
		pz_q    <= {1'b0, p_q} + (PLW + 1)'(zc_q);
		total_q <= TW'(txp);
	end

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index <= REG_EPSILON);
	assign in_ready  = (settle_q == 2'd0) && !q_full;
	assign accept    = in_valid && in_ready;

	assign ahead   = {1'b0, wp_q} + 1'b1 - {1'b0, ep_q};
	assign last_c  = ({1'b0, ep_q} + 1'b1) == {1'b0, total_q};

	always_comb begin
		store = (command == CMD_SAMPLE) && (wp_q < total_q);
		if (command == CMD_SAMPLE) begin
			emit = store && (ep_q < total_q) && (ahead > pz_q);
		end else begin
			emit = (wp_q == total_q) && (ep_q < total_q);
		end
	end

	assign mem_we    = accept && store;
	assign mem_waddr = wa_q;
	assign mem_wdata = phi_value;
	assign q_push    = accept && emit;
	assign q_data    = {last_c, ra_q, ek_q, ej_q, ei_q};

	assign ext_x      = xc_q;
	assign ext_y      = yc_q;
	assign ext_z      = zc_q;
	assign plane_size = p_q;
	assign eps        = eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_x_q  <= EXT_X_W'(64);
			ext_y_q  <= EXT_YZ_W'(64);
			ext_z_q  <= EXT_YZ_W'(64);
			eps_q    <= EPS_W'(1);
			settle_q <= 2'd2;
			wp_q     <= '0;
			ep_q     <= '0;
			ei_q     <= '0;
			ej_q     <= '0;
			ek_q     <= '0;
			wa_q     <= '0;
			ra_q     <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_EXTENT_X: ext_x_q <= cfg_data[EXT_X_W-1:0];
				REG_EXTENT_Y: ext_y_q <= cfg_data[EXT_YZ_W-1:0];
				REG_EXTENT_Z: ext_z_q <= cfg_data[EXT_YZ_W-1:0];
				REG_EPSILON:  eps_q   <= cfg_data;
				default:      eps_q   <= eps_q;
			endcase
			settle_q <= 2'd2;
			wp_q     <= '0;
			ep_q     <= '0;
			ei_q     <= '0;
			ej_q     <= '0;
			ek_q     <= '0;
			wa_q     <= '0;
			ra_q     <= '0;
		end else begin
			if (settle_q != 2'd0) begin
				settle_q <= settle_q - 1'b1;
			end
			if (accept) begin
				if (store) begin
					wp_q <= wp_q + 1'b1;
					wa_q <= wa_q + 1'b1;
				end
				if (emit) begin
					ra_q <= ra_q + 1'b1;
					if (last_c) begin
						// region done, start over
						wp_q <= '0;
						ep_q <= '0;
						ei_q <= '0;
						ej_q <= '0;
						ek_q <= '0;
					end else begin
						ep_q <= ep_q + 1'b1;
						if (({1'b0, ek_q} + 1'b1) < {1'b0, zc_q}) begin
							ek_q <= ek_q + 1'b1;
						end else begin
							ek_q <= '0;
							if (({1'b0, ej_q} + 1'b1) < {1'b0, yc_q}) begin
								ej_q <= ej_q + 1'b1;
							end else begin
								ej_q <= '0;
								ei_q <= ei_q + 1'b1;
							end
						end
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_emit_behind_write: assert property (@(posedge clk) disable iff (!arst_n)
		ep_q <= wp_q)
		else $error("answered voxel ahead of stored voxel");
	a_write_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		(settle_q == 2'd0) |-> (wp_q <= total_q))
		else $error("write position beyond region");
`endif

endmodule

>>> rtl/lsmc_back.sv
// Back end: neighbourhood fetch, shared square root and divider, curvature sum and output.
module lsmc_back import lsmc_pkg::*; #(
	parameter int MAX_PLANES = MAX_PLANES_DEF,
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF,
	localparam int XW  = $clog2(MAX_PLANES + 1),
	localparam int YW  = $clog2(MAX_ROWS + 1),
	localparam int ZW  = $clog2(MAX_COLS + 1),
	localparam int PLW = $clog2(MAX_ROWS * MAX_COLS + 1),
	localparam int AW  = $clog2(2 * MAX_ROWS * MAX_COLS + 2 * MAX_COLS + QUEUE_DEPTH + 3),
	localparam int EW  = XW + YW + ZW + AW + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  logic [EW-1:0]     q_data,
	output logic              q_pop,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [PHI_W-1:0]  mem_rdata,
	input  logic [XW-1:0]     ext_x,
	input  logic [YW-1:0]     ext_y,
	input  logic [ZW-1:0]     ext_z,
	input  logic [PLW-1:0]    plane_size,
	input  logic [EPS_W-1:0]  eps,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [CURV_W-1:0] curvature,
	output logic              last
);

	localparam int DW = PHI_W + 1;  // difference
	localparam int TW = PHI_W + 2;  // cross term
	localparam int AWD = PHI_W + 3; // scaled one-sided difference
	localparam int MW = PHI_W + 2;  // magnitude
	localparam int SW = 2 * MW + 2; // sum of squares
	localparam int NW = 49;         // dividend
	localparam int QW = 16;         // quotient
	localparam int ACW = CURV_W + 1;

	typedef enum logic [3:0] {
		B_IDLE, B_SETUP, B_READ, B_LOAD, B_SQ, B_SQRT, B_PREP, B_DIV, B_ACC, B_DONE
	} bstate_t;

	bstate_t state_q;
	logic [4:0] cnt_q;
	logic [2:0] term_q;

	logic [XW-1:0] i_q;
	logic [YW-1:0] j_q;
	logic [ZW-1:0] k_q;
	logic [AW-1:0] ea_q;
	logic          last_q;

	logic [AW-1:0] pm_q, pp_q, zm_q, zp_q, km_q, kp_q;
	logic [AW+PLW-1:0] p_wide;
	logic [AW+ZW-1:0]  z_wide;

	logic rvalid_s1;
	logic [4:0] ridx_s1;
	logic signed [PHI_W-1:0] u_q [NB_COUNT];

	logic signed [AWD-1:0] a_q;
	logic signed [TW-1:0]  t1_q, t2_q;
	logic [2*MW-1:0] prod_s1;
	logic [SW-1:0]   s_q, s_sum;
	logic [63:0]     x_q, res_q, bit_q, root_try;
	logic [NW-1:0]   num_q, dv_q;
	logic [QW-1:0]   q_q;
	logic signed [ACW-1:0] acc_q, n_c, qs;

	nb_off_t nb;
	logic signed [DW-1:0] da, d1a, d1b, d2a, d2b, cr, cp, cc;
	logic signed [AWD-1:0] sel;
	logic [AWD-1:0] sel_u, mag_u;
	logic [MW-1:0]  mag;
	logic [MW-1:0]  a_mag;
	logic [31:0]    r_c;

	function automatic logic signed [DW-1:0] dif(input logic signed [PHI_W-1:0] x,
	                                           input logic signed [PHI_W-1:0] y);
		return {x[PHI_W-1], x} - {y[PHI_W-1], y};
	endfunction

	assign p_wide = {{AW{1'b0}}, plane_size};
	assign z_wide = {{AW{1'b0}}, ext_z};

	// neighbour address around the voxel, ring buffer wraps naturally
	always_comb begin
		logic [AW-1:0] oi, oj, ok;
		nb = nb_offset(cnt_q);
		case (nb.di)
			OFF_MINUS: oi = pm_q;
			OFF_PLUS:  oi = pp_q;
			default:   oi = '0;
		endcase
		case (nb.dj)
			OFF_MINUS: oj = zm_q;
			OFF_PLUS:  oj = zp_q;
			default:   oj = '0;
		endcase
		case (nb.dk)
			OFF_MINUS: ok = km_q;
			OFF_PLUS:  ok = kp_q;
			default:   ok = '0;
		endcase
		mem_raddr = ea_q + oi + oj + ok;
	end

	assign mem_re = (state_q == B_READ) && (cnt_q < 5'(NB_COUNT));
	assign q_pop  = (state_q == B_IDLE) && !q_empty;

	assign cr = dif(u_q[NB_U5], u_q[NB_U3]);
	assign cp = dif(u_q[NB_U7], u_q[NB_U1]);
	assign cc = dif(u_q[NB_U4P], u_q[NB_U4M]);

	// one-sided difference and cross terms of the current direction
	always_comb begin
		case (term_q)
			3'd0: begin
				da = dif(u_q[NB_U5], u_q[NB_U4]);
				d1a = dif(u_q[NB_U8], u_q[NB_U2]);   d1b = cp;
				d2a = dif(u_q[NB_U5P], u_q[NB_U5M]); d2b = cc;
			end
			3'd1: begin
				da = dif(u_q[NB_U4], u_q[NB_U3]);
				d1a = dif(u_q[NB_U6], u_q[NB_U0]);   d1b = cp;
				d2a = dif(u_q[NB_U3P], u_q[NB_U3M]); d2b = cc;
			end
			3'd2: begin
				da = dif(u_q[NB_U7], u_q[NB_U4]);
				d1a = dif(u_q[NB_U8], u_q[NB_U6]);   d1b = cr;
				d2a = dif(u_q[NB_U7P], u_q[NB_U7M]); d2b = cc;
			end
			3'd3: begin
				da = dif(u_q[NB_U4], u_q[NB_U1]);
				d1a = dif(u_q[NB_U2], u_q[NB_U0]);   d1b = cr;
				d2a = dif(u_q[NB_U1P], u_q[NB_U1M]); d2b = cc;
			end
			3'd4: begin
				da = dif(u_q[NB_U4P], u_q[NB_U4]);
				d1a = dif(u_q[NB_U5P], u_q[NB_U3P]); d1b = cr;
				d2a = dif(u_q[NB_U7P], u_q[NB_U1P]); d2b = cp;
			end
			default: begin
				da = dif(u_q[NB_U4], u_q[NB_U4M]);
				d1a = dif(u_q[NB_U5M], u_q[NB_U3M]); d1b = cr;
				d2a = dif(u_q[NB_U7M], u_q[NB_U1M]); d2b = cp;
			end
		endcase
	end

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sel = a_q;
			2'd1:    sel = {t1_q[TW-1], t1_q};
			default: sel = {t2_q[TW-1], t2_q};
		endcase
		sel_u = sel;
		mag_u = sel_u[AWD-1] ? (~sel_u + 1'b1) : sel_u;
		mag   = mag_u[MW-1:0];
	end

	assign s_sum    = s_q + SW'(prod_s1);
	assign root_try = res_q + bit_q;
	assign r_c      = res_q[31:0];
	assign a_mag    = a_q[AWD-1] ? MW'(-a_q) : MW'(a_q);
	assign qs       = {{(ACW - QW){1'b0}}, q_q};
	assign n_c      = a_q[AWD-1] ? -qs : qs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			cnt_q     <= '0;
			term_q    <= '0;
			rvalid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			rvalid_s1 <= mem_re;
			if (out_valid && out_ready && (state_q != B_DONE)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= B_SETUP;
					end
				end
				B_SETUP: begin
					cnt_q   <= '0;
					state_q <= B_READ;
				end
				B_READ: begin
					if (mem_re) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (rvalid_s1) begin
						term_q  <= '0;
						state_q <= B_LOAD;
					end
				end
				B_LOAD: begin
					cnt_q   <= '0;
					state_q <= B_SQ;
				end
				B_SQ: begin
					if (cnt_q == 5'd3) begin
						cnt_q   <= '0;
						state_q <= B_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				B_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						state_q <= B_PREP;
					end
				end
				B_PREP: begin
					cnt_q   <= '0;
					state_q <= (r_c == '0) ? B_ACC : B_DIV;
				end
				B_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(QW - 1)) begin
						state_q <= B_ACC;
					end
				end
				B_ACC: begin
					if (term_q == 3'd5) begin
						state_q <= B_DONE;
					end else begin
						term_q  <= term_q + 1'b1;
						state_q <= B_LOAD;
					end
				end
				B_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rvalid_s1) begin
			u_q[ridx_s1] <= mem_rdata;
		end
		ridx_s1 <= cnt_q;
		case (state_q)
			B_IDLE: begin
				{last_q, ea_q, k_q, j_q, i_q} <= q_data;
				acc_q <= '0;
			end
			B_SETUP: begin
				// clamp at the region faces: the voxel stands in for a missing neighbour
				pm_q <= (i_q != '0) ? -p_wide[AW-1:0] : '0;
				pp_q <= (({1'b0, i_q} + 1'b1) < {1'b0, ext_x}) ? p_wide[AW-1:0] : '0;
				zm_q <= (j_q != '0) ? -z_wide[AW-1:0] : '0;
				zp_q <= (({1'b0, j_q} + 1'b1) < {1'b0, ext_y}) ? z_wide[AW-1:0] : '0;
				km_q <= (k_q != '0) ? '1 : '0;
				kp_q <= (({1'b0, k_q} + 1'b1) < {1'b0, ext_z}) ? AW'(1) : '0;
			end
			B_LOAD: begin
				a_q  <= {da, 2'b00};
				t1_q <= {d1a[DW-1], d1a} + {d1b[DW-1], d1b};
				t2_q <= {d2a[DW-1], d2a} + {d2b[DW-1], d2b};
				s_q  <= SW'({eps, 4'b0000});
			end
			B_SQ: begin
				if (cnt_q != 5'd3) begin
					prod_s1 <= mag * mag;
				end
				if (cnt_q != 5'd0) begin
					s_q <= s_sum;
				end
				if (cnt_q == 5'd3) begin
					x_q   <= {{(64 - SW - 8){1'b0}}, s_sum, 8'h00};
					res_q <= '0;
					bit_q <= 64'd1 << 62;
				end
			end
			B_SQRT: begin
				if (x_q >= root_try) begin
					x_q   <= x_q - root_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			B_PREP: begin
				num_q <= NW'({a_mag, 18'd0}) + NW'(r_c);
				dv_q  <= NW'({r_c, 1'b0}) << (QW - 1);
				q_q   <= '0;
			end
			B_DIV: begin
				if (num_q >= dv_q) begin
					num_q <= num_q - dv_q;
					q_q   <= {q_q[QW-2:0], 1'b1};
				end else begin
					q_q <= {q_q[QW-2:0], 1'b0};
				end
				dv_q <= dv_q >> 1;
			end
			B_ACC: begin
				// even directions are the forward faces
				if (r_c == '0) begin
					acc_q <= acc_q;
				end else if (term_q[0]) begin
					acc_q <= acc_q - n_c;
				end else begin
					acc_q <= acc_q + n_c;
				end
			end
			B_DONE: begin
				if (!out_valid || out_ready) begin
					if (acc_q > ACW'(131071)) curvature <= 18'sh1FFFF;
					else if (acc_q < -ACW'(131072)) curvature <= -18'sh20000;
					else curvature <= acc_q[CURV_W-1:0];
					last <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DONE) |-> (acc_q <= 19'sd49158 && acc_q >= -19'sd49158))
		else $error("curvature sum beyond six unit normals");
	a_read_in_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_s1 |-> (state_q == B_READ))
		else $error("read data returned outside fetch");
`endif

endmodule

>>> rtl/level_set_mean_curvature_3d.sv
// Mean curvature of a streamed 3D level set: voxels in raster order in, one word per voxel out.
// Samples (signed Q16.8) arrive plane by plane, row by row, column fastest; the block keeps
// a ring of two planes, two rows and a few voxels in one RAM, so a voxel is answered once
// plane size + row length + 1 samples have arrived, and drain words flush the tail of the region.
// Each answer (signed Q4.13, saturated, last set on the final voxel) takes 19 neighbour reads from
// the single RAM read port, then six directions, each through one shared iterative square root
// and restoring divider. The front keeps accepting samples while fewer than four voxels wait
// for the back. After any register write, which also restarts the region, the input is not
// ready until the derived sizes have settled. The store needs no clearing after reset; only
// written entries are ever read.
module level_set_mean_curvature_3d import lsmc_pkg::*; #(
	parameter int MAX_PLANES = MAX_PLANES_DEF,
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    command,
	input  logic signed [PHI_W-1:0] phi_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [CURV_W-1:0] curvature,
	output logic                    last
);

	localparam int XW  = $clog2(MAX_PLANES + 1);
	localparam int YW  = $clog2(MAX_ROWS + 1);
	localparam int ZW  = $clog2(MAX_COLS + 1);
	localparam int PLW = $clog2(MAX_ROWS * MAX_COLS + 1);
	localparam int AW  = $clog2(2 * MAX_ROWS * MAX_COLS + 2 * MAX_COLS + QUEUE_DEPTH + 3);
	localparam int EW  = XW + YW + ZW + AW + 1;

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [PHI_W-1:0]  mem_wdata, mem_rdata;
	logic              q_push, q_full, q_pop, q_empty;
	logic [EW-1:0]     q_in, q_out;
	logic [XW-1:0]     ext_x;
	logic [YW-1:0]     ext_y;
	logic [ZW-1:0]     ext_z;
	logic [PLW-1:0]    plane_size;
	logic [EPS_W-1:0]  eps;

	lsmc_front #(
		.MAX_PLANES(MAX_PLANES), .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)
	) u_front (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .command, .phi_value,
		.mem_we, .mem_waddr, .mem_wdata,
		.q_push, .q_data(q_in), .q_full,
		.ext_x, .ext_y, .ext_z, .plane_size, .eps
	);

	lsmc_fifo #(
		.WIDTH(EW), .DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk, .arst_n,
		.push(q_push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .pop_data(q_out), .empty(q_empty)
	);

	lsmc_ram #(
		.WIDTH(PHI_W), .DEPTH(2 ** AW)
	) u_store (
		.clk,
		.we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
	);

	lsmc_back #(
		.MAX_PLANES(MAX_PLANES), .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)
	) u_back (
		.clk, .arst_n,
		.q_empty, .q_data(q_out), .q_pop,
		.mem_re, .mem_raddr, .mem_rdata,
		.ext_x, .ext_y, .ext_z, .plane_size, .eps,
		.out_valid, .out_ready, .curvature, .last
	);

endmodule

>>> tb/level_set_mean_curvature_3d_tb.sv
// Self-checking testbench for the streamed 3D mean curvature block.
module level_set_mean_curvature_3d_tb;
	import lsmc_pkg::*;

	localparam int STORE_DEPTH = 2 * MAX_ROWS_DEF * MAX_COLS_DEF + 2 * MAX_COLS_DEF + 1;
	localparam int IDLE_WAIT   = 400;       // settle time after the last expected word has been received
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 700;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

	typedef struct {
		logic signed [CURV_W-1:0] curv;
		logic                     lst;
	} curv_word_t;

	typedef struct {
		bit                       is_cfg;
		logic [CFG_IDX_W-1:0]     idx;
		logic [CFG_DATA_W-1:0]    data;
		logic                     cmd;
		logic signed [PHI_W-1:0]  phi;
		bit                       typed;     // expectation written in the row
		bit                       has_word;
		logic signed [CURV_W-1:0] curv;
		logic                     lst;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = CMD_SAMPLE;
	logic signed [PHI_W-1:0] phi_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CURV_W-1:0] curvature;
	logic last;

	level_set_mean_curvature_3d i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command), .phi_value(phi_value),
		.out_valid(out_valid), .out_ready(out_ready), .curvature(curvature), .last(last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// curvature predictor state
	int unsigned reg_x = 64, reg_y = 64, reg_z = 64, reg_eps = 1;
	int phi_store [STORE_DEPTH];
	longint wr_pos = 0, em_pos = 0;

	curv_word_t curv_q[$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	int items_sent = 0;

	function automatic longint clamp_ext(int unsigned v, int unsigned mx);
		if (v < 1) return 1;
		if (v > mx) return mx;
		return v;
	endfunction

	function automatic longint unsigned root64(longint unsigned x);
		longint unsigned res = 0;
		longint unsigned b = 64'h4000_0000_0000_0000;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned mag_sq(longint v);
		longint unsigned m = (v < 0) ? -v : v;
		return m * m;
	endfunction

	function automatic longint unit_normal(longint a, longint t1, longint t2);
		longint unsigned s = longint'(reg_eps) * 16 + mag_sq(a) + mag_sq(t1) + mag_sq(t2);
		longint unsigned r = root64(s << 8);
		longint unsigned m = (a < 0) ? -a : a;
		longint unsigned q;
		if (r == 0) return 0;
		q = ((m << 18) + r) / (2 * r);
		return (a < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint tap(longint a, longint b, longint c, longint p, longint z);
		return phi_store[(a * p + b * z + c) % STORE_DEPTH];
	endfunction

	function automatic longint curv_at(longint e, longint nx, longint ny, longint nz);
		longint p = ny * nz;
		longint i = e / p, j = (e % p) / nz, k = (e % p) % nz;
		longint im = (i > 0) ? i - 1 : i, ip = (i + 1 < nx) ? i + 1 : i;
		longint jm = (j > 0) ? j - 1 : j, jp = (j + 1 < ny) ? j + 1 : j;
		longint km = (k > 0) ? k - 1 : k, kp = (k + 1 < nz) ? k + 1 : k;
		longint u0, u1, u1m, u1p, u2, u3, u3m, u3p, u4, u4m, u4p;
		longint u5, u5m, u5p, u6, u7, u7m, u7p, u8, cr, cp, cc, sum;
		u0 = tap(im, jm, k, p, nz);
		u1 = tap(im, j, k, p, nz); u1m = tap(im, j, km, p, nz); u1p = tap(im, j, kp, p, nz);
		u2 = tap(im, jp, k, p, nz);
		u3 = tap(i, jm, k, p, nz); u3m = tap(i, jm, km, p, nz); u3p = tap(i, jm, kp, p, nz);
		u4 = tap(i, j, k, p, nz); u4m = tap(i, j, km, p, nz); u4p = tap(i, j, kp, p, nz);
		u5 = tap(i, jp, k, p, nz); u5m = tap(i, jp, km, p, nz); u5p = tap(i, jp, kp, p, nz);
		u6 = tap(ip, jm, k, p, nz);
		u7 = tap(ip, j, k, p, nz); u7m = tap(ip, j, km, p, nz); u7p = tap(ip, j, kp, p, nz);
		u8 = tap(ip, jp, k, p, nz);
		cr = u5 - u3; cp = u7 - u1; cc = u4p - u4m;
		sum = unit_normal(4 * (u5 - u4), (u8 - u2) + cp, (u5p - u5m) + cc)
		    - unit_normal(4 * (u4 - u3), (u6 - u0) + cp, (u3p - u3m) + cc)
		    + unit_normal(4 * (u7 - u4), (u8 - u6) + cr, (u7p - u7m) + cc)
		    - unit_normal(4 * (u4 - u1), (u2 - u0) + cr, (u1p - u1m) + cc)
		    + unit_normal(4 * (u4p - u4), (u5p - u3p) + cr, (u7p - u1p) + cp)
		    - unit_normal(4 * (u4 - u4m), (u5m - u3m) + cr, (u7m - u1m) + cp);
		if (sum > 131071) sum = 131071;
		if (sum < -131072) sum = -131072;
		return sum;
	endfunction

	function automatic longint region_total();
		return clamp_ext(reg_x, MAX_PLANES_DEF) * clamp_ext(reg_y, MAX_ROWS_DEF)
		     * clamp_ext(reg_z, MAX_COLS_DEF);
	endfunction

	function automatic bit predict_curvature(logic cmd, logic signed [PHI_W-1:0] phi,
	                                         output curv_word_t w);
		longint nx = clamp_ext(reg_x, MAX_PLANES_DEF);
		longint ny = clamp_ext(reg_y, MAX_ROWS_DEF);
		longint nz = clamp_ext(reg_z, MAX_COLS_DEF);
		longint p = ny * nz, total = nx * ny * nz;
		bit fire = 0;
		w.curv = '0;
		w.lst = 1'b0;
		if (cmd == CMD_SAMPLE) begin
			if (wr_pos >= total) return 0;
			phi_store[wr_pos % STORE_DEPTH] = int'(phi);
			wr_pos++;
			if (em_pos < total && wr_pos - em_pos > p + nz) fire = 1;
		end else if (wr_pos == total && em_pos < total)
			fire = 1;
		if (!fire) return 0;
		w.curv = CURV_W'(curv_at(em_pos, nx, ny, nz));
		w.lst = (em_pos + 1 == total);
		em_pos++;
		if (em_pos >= total) begin
			wr_pos = 0;
			em_pos = 0;
		end
		return 1;
	endfunction

	function automatic void predict_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_EXTENT_X: reg_x = d[EXT_X_W-1:0];
			REG_EXTENT_Y: reg_y = d[EXT_YZ_W-1:0];
			REG_EXTENT_Z: reg_z = d[EXT_YZ_W-1:0];
			REG_EPSILON:  reg_eps = d;
			default: return;
		endcase
		wr_pos = 0;
		em_pos = 0;
	endfunction

	// receiver: checks each accepted word and cycles through four out_ready patterns
	always @(posedge clk) begin
		curv_word_t w;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (curv_q.size() == 0) begin
				$error("unexpected word: curvature %0d last %0b", curvature, last);
				errors++;
			end else begin
				w = curv_q.pop_front();
				if (curvature !== w.curv) begin
					$error("curvature: expected %0d, got %0d", w.curv, curvature);
					errors++;
				end
				if (last !== w.lst) begin
					$error("last: expected %0b, got %0b", w.lst, last);
					errors++;
				end
			end
		end
		case ((cycles / 97) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 4) == 0);
			default: out_ready <= (cycles % 40) < 30;
		endcase
	end

	// all waits return on a rising edge, so drives land at the edge
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (curv_q.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		predict_cfg(idx, d);
	endtask

	task automatic configure(int unsigned x, int unsigned y, int unsigned z, int unsigned eps);
		wait_idle();
		write_reg(REG_EXTENT_X, CFG_DATA_W'(x));
		write_reg(REG_EXTENT_Y, CFG_DATA_W'(y));
		write_reg(REG_EXTENT_Z, CFG_DATA_W'(z));
		write_reg(REG_EPSILON, CFG_DATA_W'(eps));
	endtask

	// returns the predicted word; the caller decides whether to queue it
	task automatic send_word(logic cmd, logic signed [PHI_W-1:0] phi, output bit has,
	                         output curv_word_t w);
		if (cfg_valid) cfg_valid <= 1'b0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= cmd;
		phi_value <= phi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		has = predict_curvature(cmd, phi, w);
	endtask

	task automatic send_checked(logic cmd, logic signed [PHI_W-1:0] phi);
		bit has;
		curv_word_t w;
		send_word(cmd, phi, has, w);
		if (has) curv_q.push_back(w);
		items_sent++;
	endtask

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		stim_row_t r = '{default: '0};
		r.is_cfg = 1;
		r.idx = idx;
		r.data = d;
		return r;
	endfunction

	function automatic stim_row_t item_row(logic cmd, logic signed [PHI_W-1:0] phi, bit typed,
	                                       bit has_word, logic lst);
		stim_row_t r = '{default: '0};
		r.cmd = cmd;
		r.phi = phi;
		r.typed = typed;
		r.has_word = has_word;
		r.curv = '0;
		r.lst = lst;
		return r;
	endfunction

	// one region with a given pattern of values; may be cut short or padded with noise
	task automatic run_region(int style, bit truncate);
		longint total = region_total();
		longint n = truncate ? $urandom_range(0, total - 1) : total;
		int sx = $urandom_range(0, 4095) - 2048, sy = $urandom_range(0, 4095) - 2048;
		int sz = $urandom_range(0, 4095) - 2048, base = $urandom_range(0, 65535) - 32768;
		logic signed [PHI_W-1:0] phi;
		for (longint e = 0; e < n; e++) begin
			case (style)
				0: phi = PHI_W'($urandom);
				1: phi = PHI_W'($urandom_range(0, 2047) - 1024);
				default: phi = PHI_W'(base + sx * int'(e / 97) + sy * int'(e % 13)
				             + sz * int'(e % 7) + $urandom_range(0, 15));
			endcase
			if ($urandom_range(0, 40) == 0) send_checked(CMD_DRAIN, '0);
			send_checked(CMD_SAMPLE, phi);
		end
		if (truncate) return;
		if ($urandom_range(0, 7) == 0) send_checked(CMD_SAMPLE, PHI_W'($urandom));
		while (wr_pos != 0) send_checked(CMD_DRAIN, PHI_W'($urandom));
		if ($urandom_range(0, 7) == 0) send_checked(CMD_DRAIN, PHI_W'($urandom));
	endtask

	initial begin
		stim_row_t rows[$];
		bit has;
		bit paused = 0;
		curv_word_t w;

		// single voxel: every neighbour clamps to itself, so the answer is zero
		rows.push_back(cfg_row(REG_EXTENT_X, 16'd0));
		rows.push_back(cfg_row(REG_EXTENT_Y, 16'd0));
		rows.push_back(cfg_row(REG_EXTENT_Z, 16'd0));
		rows.push_back(cfg_row(REG_EPSILON, 16'd0));
		rows.push_back(cfg_row(REG_UNUSED, 16'hFFFF));
		rows.push_back(item_row(CMD_SAMPLE, 24'sh7FFFFF, 1, 0, 0));
		rows.push_back(item_row(CMD_DRAIN, 24'sh000000, 1, 1, 1));
		rows.push_back(item_row(CMD_DRAIN, 24'shFFFFFF, 1, 0, 0));
		rows.push_back(item_row(CMD_SAMPLE, 24'sh800000, 1, 0, 0));
		rows.push_back(item_row(CMD_SAMPLE, 24'sh123456, 1, 0, 0));   // dropped
		rows.push_back(item_row(CMD_DRAIN, 24'sh000000, 1, 1, 1));
		// 2x2x2 with steep extremes and the largest epsilon
		rows.push_back(cfg_row(REG_EXTENT_X, 16'd2));
		rows.push_back(cfg_row(REG_EXTENT_Y, 16'd2));
		rows.push_back(cfg_row(REG_EXTENT_Z, 16'd2));
		rows.push_back(cfg_row(REG_EPSILON, 16'hFFFF));
		rows.push_back(item_row(CMD_DRAIN, 24'sh000000, 1, 0, 0));
		rows.push_back(item_row(CMD_SAMPLE, 24'sh7FFFFF, 0, 0, 0));
		rows.push_back(item_row(CMD_SAMPLE, 24'sh800000, 0, 0, 0));
		rows.push_back(item_row(CMD_SAMPLE, 24'sh000000, 0, 0, 0));
		rows.push_back(item_row(CMD_SAMPLE, 24'sh000001, 0, 0, 0));
		rows.push_back(item_row(CMD_SAMPLE, 24'shFFFFFF, 0, 0, 0));
		rows.push_back(item_row(CMD_SAMPLE, 24'sh555555, 0, 0, 0));
		rows.push_back(item_row(CMD_SAMPLE, 24'shAAAAAA, 0, 0, 0));
		rows.push_back(item_row(CMD_SAMPLE, 24'sh7FFFFF, 0, 0, 0));
		for (int d = 0; d < 7; d++) rows.push_back(item_row(CMD_DRAIN, 24'sh0, 0, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) begin
			if (rows[r].is_cfg) begin
				if (r > 0 && !rows[r - 1].is_cfg) wait_idle();
				write_reg(rows[r].idx, rows[r].data);
			end else begin
				send_word(rows[r].cmd, rows[r].phi, has, w);
				if (rows[r].typed) begin
					w.curv = rows[r].curv;
					w.lst = rows[r].lst;
					has = rows[r].has_word;
				end
				if (has) curv_q.push_back(w);
			end
		end

		// extent extremes, the oversize values clamp to the parameters
		configure(16'h01FF, 1, 1, $urandom_range(0, 65535));
		run_region(0, 0);
		configure(1, 1, 64, 0);
		run_region(2, 0);
		configure(1, 127, 1, 16'hFFFF);
		run_region(1, 0);

		while (items_sent < RANDOM_ITEMS) begin
			if (!paused && items_sent > RANDOM_ITEMS / 2) begin
				paused = 1;
				in_valid <= 1'b0;
				burst_left = 0;
				while (curv_q.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			if ($urandom_range(0, 1) == 0 || wr_pos != 0) begin
				case ($urandom_range(0, 5))
					0: configure($urandom_range(1, 3), $urandom_range(1, 4),
					             $urandom_range(1, 5), 0);
					1: configure($urandom_range(1, 3), $urandom_range(1, 4),
					             $urandom_range(1, 5), 16'hFFFF);
					default: configure($urandom_range(1, 3), $urandom_range(1, 4),
					                   $urandom_range(1, 5), $urandom_range(0, 65535));
				endcase
			end
			run_region($urandom_range(0, 2), $urandom_range(0, 9) == 0);
		end

		wait_idle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
